// File: rtl/timed_cue_list_with_cursor_macros.svh
// ----------------------------------------------------------------------------
// timed cue list assertion macros
// concurrent assertion helpers clocked on i_clk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef TIMED_CUE_LIST_WITH_CURSOR_MACROS_SVH
`define TIMED_CUE_LIST_WITH_CURSOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// shared types, sizes and codes of the timed cue list
// ----------------------------------------------------------------------------
package tcl_pkg;

    // table sizing
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int TIME_W      = 48;
    localparam int HANDLE_W    = 16;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // stream widths
    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SORT   = 3'd1,
        OP_GET    = 3'd2,
        OP_REWIND = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    // one stored cue, start time in the lowest bits
    typedef struct packed {
        logic [HANDLE_W-1:0]      handle;
        logic signed [TIME_W-1:0] stop;
        logic signed [TIME_W-1:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one result, status in the lowest bits
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [HANDLE_W-1:0]    found_handle;
        t_status                status;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// File: rtl/timed_cue_list_with_cursor.sv
// Add, rewind, clear and unused codes go from idle straight to the done state, which loads the output register.
// Get checks each cue the cursor visits in turn (up to the table depth), then goes to the done state.
// Sort walks each held entry i against every later entry j: one compare per memory read in the walk.
// Throughput: one transaction at a time; the next is taken once the sequencer is idle again.
// Reset: synchronous active low; table empties and cursor exhausted, no clearing pass.
// Table contents need no reset because only entries below the count are ever read.
// ----------------------------------------------------------------------------
// timed_cue_list_with_cursor
// timed cue table with a read cursor: add, exchange sort by start time,
// get with stop-time skipping, rewind and clear, run by a small sequencer
// over one memory and one shared comparator
// ----------------------------------------------------------------------------
module timed_cue_list_with_cursor
    import tcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: cue_start[47:0], cue_stop[95:48], cue_handle[111:96], query_time[159:112]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: operation[2:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    // master side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: status[1:0], found_handle[17:2], entry_count[24:18], zero pad[31:25]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    `include "timed_cue_list_with_cursor_macros.svh"

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_GET_CHK  = 6'b000010,
        ST_SORT_LDI = 6'b000100,
        ST_SORT_CMP = 6'b001000,
        ST_SORT_WRI = 6'b010000,
        ST_DONE     = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_cursor, n_cursor;
    logic                     r_cur_valid, n_cur_valid;
    logic [CNT_W-1:0]         r_i, n_i;
    logic [CNT_W-1:0]         r_j, n_j;
    logic signed [TIME_W-1:0] r_query, n_query;
    t_entry                   r_cur, n_cur;
    t_status                  r_status, n_status;
    logic [HANDLE_W-1:0]      r_handle, n_handle;
    logic                     r_out_valid, n_out_valid;
    t_result                  r_out, n_out;

    logic                     accept;
    t_op                      in_op;
    t_entry                   in_entry;
    logic signed [TIME_W-1:0] in_query;

    logic                     we;
    logic [IDX_W-1:0]         waddr;
    t_entry                   wdata;
    logic [IDX_W-1:0]         raddr;
    t_entry                   rdata;

    logic signed [TIME_W-1:0] cmp_a, cmp_b;
    logic                     gt;

    logic [CNT_W-1:0]         cursor_next;
    logic [CNT_W-1:0]         i_next;
    logic [CNT_W-1:0]         j_next;

    // input unpacking
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_op    = t_op'(s_axis_tuser);
    assign in_entry = t_entry'(s_axis_tdata[ENTRY_W-1:0]);
    assign in_query = s_axis_tdata[ENTRY_W +: TIME_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, r_out};

    assign cursor_next = r_cursor + 1'b1;
    assign i_next      = r_i + 1'b1;
    assign j_next      = r_j + 1'b1;

    // cue table
    tcl_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shared comparator: query against stop during get, held start against read start in sort
    always_comb begin
        if (r_state == ST_GET_CHK) begin
            cmp_a = r_query;
            cmp_b = rdata.stop;
        end else begin
            cmp_a = r_cur.start;
            cmp_b = rdata.start;
        end
    end

    tcl_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (gt)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_cur_valid = r_cur_valid;
        n_i         = r_i;
        n_j         = r_j;
        n_query     = r_query;
        n_cur       = r_cur;
        n_status    = r_status;
        n_handle    = r_handle;
        n_out       = r_out;
        n_out_valid = r_out_valid && !m_axis_tready;
        we          = 1'b0;
        waddr       = r_count[IDX_W-1:0];
        wdata       = in_entry;
        raddr       = r_cursor[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = STAT_OK;
                    n_handle = '0;
                    n_state  = ST_DONE;
                    case (in_op)
                        OP_ADD: begin
                            if (r_count < CNT_W'(TABLE_DEPTH)) begin
                                we = 1'b1;
                                if (r_count == '0) begin
                                    n_cursor    = '0;
                                    n_cur_valid = 1'b1;
                                end
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = STAT_FULL;
                            end
                        end
                        OP_SORT: begin
                            if (r_count >= CNT_W'(2)) begin
                                n_i     = '0;
                                raddr   = '0;
                                n_state = ST_SORT_LDI;
                            end
                        end
                        OP_GET: begin
                            n_query = in_query;
                            if (r_cur_valid) begin
                                n_state = ST_GET_CHK;
                            end else begin
                                n_status = STAT_EMPTY;
                            end
                        end
                        OP_REWIND: begin
                            n_cursor    = '0;
                            n_cur_valid = (r_count != '0);
                        end
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_cursor    = '0;
                            n_cur_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // cue under the cursor is on the read port
            ST_GET_CHK: begin
                n_cursor = cursor_next;
                if (gt) begin
                    // stop time before the query, skip it
                    if (cursor_next >= r_count) begin
                        n_cur_valid = 1'b0;
                        n_status    = STAT_EMPTY;
                        n_state     = ST_DONE;
                    end else begin
                        raddr = cursor_next[IDX_W-1:0];
                    end
                end else begin
                    n_handle = rdata.handle;
                    if (cursor_next >= r_count) begin
                        n_cur_valid = 1'b0;
                    end
                    n_state = ST_DONE;
                end
            end
            // hold entry i, start the walk over j
            ST_SORT_LDI: begin
                n_cur   = rdata;
                n_j     = i_next;
                raddr   = i_next[IDX_W-1:0];
                n_state = ST_SORT_CMP;
            end
            // entry j on the read port, swapped with the held entry when the held start is later
            ST_SORT_CMP: begin
                if (gt) begin
                    we    = 1'b1;
                    waddr = r_j[IDX_W-1:0];
                    wdata = r_cur;
                    n_cur = rdata;
                end
                if (j_next < r_count) begin
                    n_j   = j_next;
                    raddr = j_next[IDX_W-1:0];
                end else begin
                    n_state = ST_SORT_WRI;
                end
            end
            // put the held entry back at i, next row
            ST_SORT_WRI: begin
                we    = 1'b1;
                waddr = r_i[IDX_W-1:0];
                wdata = r_cur;
                n_i   = i_next;
                if ((i_next + 1'b1) < r_count) begin
                    raddr   = i_next[IDX_W-1:0];
                    n_state = ST_SORT_LDI;
                end else begin
                    n_state = ST_DONE;
                end
            end
            // hand the result to the output register
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out.status       = r_status;
                    n_out.found_handle = r_handle;
                    n_out.entry_count  = COUNT_OUT_W'(r_count);
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_query  <= n_query;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_handle <= n_handle;
        r_out    <= n_out;
    end

    // checks
    `TCL_ASSERT_NOW(a_cursor_in_table, r_cur_valid, r_cursor < r_count, "cursor beyond table")
    `TCL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "count above depth")
    `TCL_ASSERT_NEXT(a_add_counts, accept && (in_op == OP_ADD) && (r_count < CNT_W'(TABLE_DEPTH)), r_count == $past(r_count) + 1'b1, "add did not grow table")
    `TCL_ASSERT_NOW(a_handle_zero, r_out_valid && (r_out.status != STAT_OK), r_out.found_handle == '0, "handle on failed op")

endmodule

// File: rtl/tcl_cmp.sv
// ----------------------------------------------------------------------------
// tcl_cmp
// shared signed time comparator used by both the sort and the get scan
// ----------------------------------------------------------------------------
module tcl_cmp
    import tcl_pkg::*;
(
    input  logic signed [TIME_W-1:0] i_a,
    input  logic signed [TIME_W-1:0] i_b,
    output logic                     o_gt
);

    // two's complement greater-than
    assign o_gt = (i_a > i_b);

endmodule

// File: rtl/tcl_store.sv
// ----------------------------------------------------------------------------
// tcl_store
// cue table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcl_store
    import tcl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
